>>> design/rounded_rect_span_generator_top_assert.svh
// ----------------------------------------------------------------------------
// rounded_rect_span_generator_top_assert
// Assertion macros for the rounded rectangle span generator.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_SPAN_GENERATOR_TOP_ASSERT_SVH
`define ROUNDED_RECT_SPAN_GENERATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rrsg_pkg.sv
// ----------------------------------------------------------------------------
// rrsg_pkg
// Shared constants and types of the rounded rectangle span generator.
// ----------------------------------------------------------------------------
package rrsg_pkg;

  localparam int MAX_RADIUS    = 31;
  localparam int COORD_BITS    = 16;
  localparam int OUT_BITS      = COORD_BITS + 1;
  localparam int SIZE_BITS     = COORD_BITS - 1;
  localparam int CFG_RAD_BITS  = 5;
  localparam int RAD_BITS      = $clog2(MAX_RADIUS + 1);
  localparam int SUM_BITS      = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
  localparam int COLOR_BITS    = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_CORNER_RADIUS = 1'b0;
  localparam logic REG_FILL_COLOR    = 1'b1;

  // Primitive kinds.
  localparam logic SPAN_LINE = 1'b0;
  localparam logic SPAN_RECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_BOT,
    ST_RECT
  } eng_state_t;

  // Command after classification: edges of the rectangle and the radius.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] x_left;
    logic signed [OUT_BITS-1:0] x_right;
    logic signed [OUT_BITS-1:0] y_top;
    logic signed [OUT_BITS-1:0] y_bot;
    logic [RAD_BITS-1:0]        radius;
  } cmd_t;

  typedef struct packed {
    logic                busy;
    logic [RAD_BITS-1:0] inset;
    logic [RAD_BITS-1:0] radius;
  } eng_status_t;

endpackage

>>> design/rrsg_cmd_front.sv
// ----------------------------------------------------------------------------
// rrsg_cmd_front
// Accepts draw requests and turns them into rectangle edges for the queue.
// ----------------------------------------------------------------------------
module rrsg_cmd_front (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rrsg_pkg::COORD_BITS-1:0] origin_x,
  input  logic signed [rrsg_pkg::COORD_BITS-1:0] origin_y,
  input  logic [rrsg_pkg::SIZE_BITS-1:0]       width,
  input  logic [rrsg_pkg::SIZE_BITS-1:0]       height,
  input  logic [rrsg_pkg::CFG_RAD_BITS-1:0]    corner_radius,
  input  logic                                 q_full,
  output logic                                 q_push,
  output rrsg_pkg::cmd_t                       q_data
);
  import rrsg_pkg::*;

  logic [RAD_BITS-1:0]     radius;
  logic [OUT_BITS-1:0]     x_ext;
  logic [OUT_BITS-1:0]     y_ext;

  // Radius above the supported bound is clamped.
  assign radius = (32'(corner_radius) > 32'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                         : RAD_BITS'(corner_radius);

  assign x_ext = {origin_x[COORD_BITS-1], origin_x};
  assign y_ext = {origin_y[COORD_BITS-1], origin_y};

  always_comb begin
    q_data.radius  = radius;
    q_data.x_left  = x_ext;
    q_data.x_right = x_ext + OUT_BITS'(width);
    q_data.y_top   = y_ext + OUT_BITS'(radius);
    q_data.y_bot   = y_ext + OUT_BITS'(height) - OUT_BITS'(radius);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

>>> design/rrsg_cmd_queue.sv
// ----------------------------------------------------------------------------
// rrsg_cmd_queue
// Short FIFO of classified commands between the front and the span engine.
// ----------------------------------------------------------------------------
module rrsg_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrsg_pkg::cmd_t push_data,
  input  logic           pop,
  output rrsg_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import rrsg_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/rrsg_span_engine.sv
// ----------------------------------------------------------------------------
// rrsg_span_engine
// Walks the corner rows of one command, runs the inset search and drives
// the registered result port.
// ----------------------------------------------------------------------------
module rrsg_span_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  rrsg_pkg::cmd_t                        q_head,
  output logic                                  q_pop,
  input  logic [rrsg_pkg::COLOR_BITS-1:0]       fill_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  span_kind,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]  x_start,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]  y_start,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]  x_end,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]  y_end,
  output logic [rrsg_pkg::COLOR_BITS-1:0]       draw_color,
  output logic                                  last,
  output rrsg_pkg::eng_status_t                 status
);
  import rrsg_pkg::*;

  typedef struct packed {
    logic init;
    logic step;
    logic emit_top;
    logic emit_bot;
    logic emit_rect;
  } eng_ctrl_t;

  eng_state_t            state;
  eng_state_t            state_next;
  eng_ctrl_t             ctrl;
  cmd_t                  cmd;
  logic [RAD_BITS-1:0]   row;
  logic [RAD_BITS-1:0]   inset;
  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   target;
  logic [OUT_BITS-1:0]   y_up;
  logic [OUT_BITS-1:0]   y_dn;
  logic                  load_ok;
  logic                  search_go;
  logic                  last_row;
  logic [RAD_BITS:0]     term;
  logic [RAD_BITS:0]     odd;

  assign load_ok   = !out_valid || !out_stall;
  assign search_go = (sum < target) && (inset < cmd.radius);
  assign last_row  = (({1'b0, row} + 1'b1) == {1'b0, cmd.radius});
  // Quarter-circle term for the next inset and the next odd square step.
  assign term = ({cmd.radius, 1'b0} - {inset, 1'b0}) - 1'b1;
  assign odd  = {row, 1'b1};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = (q_head.radius == '0) ? ST_RECT : ST_TOP;
        end
      end
      ST_TOP: begin
        if (!search_go && load_ok) begin
          state_next = ST_BOT;
        end
      end
      ST_BOT: begin
        if (load_ok) begin
          state_next = last_row ? ST_RECT : ST_TOP;
        end
      end
      ST_RECT: begin
        if (load_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        ctrl.init = !q_empty;
      end
      ST_TOP: begin
        ctrl.step     = search_go;
        ctrl.emit_top = !search_go && load_ok;
      end
      ST_BOT: begin
        ctrl.emit_bot = load_ok;
      end
      ST_RECT: begin
        ctrl.emit_rect = load_ok;
      end
      default: ctrl = '0;
    endcase
  end

  assign q_pop = ctrl.init;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      cmd    <= q_head;
      row    <= '0;
      inset  <= '0;
      sum    <= '0;
      target <= '0;
      y_up   <= q_head.y_top - 1'b1;
      y_dn   <= q_head.y_bot;
    end
    if (ctrl.step) begin
      sum   <= sum + SUM_BITS'(term);
      inset <= inset + 1'b1;
    end
    if (ctrl.emit_bot) begin
      target <= target + SUM_BITS'(odd);
      row    <= row + 1'b1;
      y_up   <= y_up - 1'b1;
      y_dn   <= y_dn + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= ctrl.emit_top || ctrl.emit_bot || ctrl.emit_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_top || ctrl.emit_bot) begin
      span_kind  <= SPAN_LINE;
      x_start    <= cmd.x_left + OUT_BITS'(inset);
      x_end      <= cmd.x_right - OUT_BITS'(inset);
      y_start    <= ctrl.emit_top ? y_up : y_dn;
      y_end      <= ctrl.emit_top ? y_up : y_dn;
      draw_color <= fill_color;
      last       <= 1'b0;
    end else if (ctrl.emit_rect) begin
      span_kind  <= SPAN_RECT;
      x_start    <= cmd.x_left;
      x_end      <= cmd.x_right;
      y_start    <= cmd.y_top;
      y_end      <= cmd.y_bot;
      draw_color <= fill_color;
      last       <= 1'b1;
    end
  end

  always_comb begin
    status.busy   = (state != ST_IDLE);
    status.inset  = inset;
    status.radius = cmd.radius;
  end

endmodule

>>> design/rounded_rect_span_generator_top.sv
// A request passes through the command queue, the engine's command register and the
// registered result port before its first result appears. The engine works on one
// request at a time, and its pace is set by the single inset adder.
// The command queue frees the front side, which keeps taking requests until it fills.
// Reset clears the configuration registers, the queue and the engine state machine.
// ----------------------------------------------------------------------------
// rounded_rect_span_generator_top
// Rounded rectangle scanline generator with an APB-style register port.
// ----------------------------------------------------------------------------
module rounded_rect_span_generator_top (
  input  logic                                   clk,
  input  logic                                   rst,
  // Draw request channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rrsg_pkg::COORD_BITS-1:0] origin_x,
  input  logic signed [rrsg_pkg::COORD_BITS-1:0] origin_y,
  input  logic [rrsg_pkg::SIZE_BITS-1:0]         width,
  input  logic [rrsg_pkg::SIZE_BITS-1:0]         height,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   span_kind,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]   x_start,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]   y_start,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]   x_end,
  output logic signed [rrsg_pkg::OUT_BITS-1:0]   y_end,
  output logic [rrsg_pkg::COLOR_BITS-1:0]        draw_color,
  output logic                                   last,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rrsg_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [rrsg_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [rrsg_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                   pready
);
  import rrsg_pkg::*;

  logic [CFG_RAD_BITS-1:0] corner_radius;
  logic [COLOR_BITS-1:0]   fill_color;
  logic                    cfg_write;
  logic                    reg_index;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  cmd_t                    q_data;
  cmd_t                    q_head;
  eng_status_t             eng_status;

  // The register port never inserts wait states. Registers sit on word
  // addresses, so the word index alone selects one.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_radius <= '0;
      fill_color    <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_CORNER_RADIUS: corner_radius <= pwdata[CFG_RAD_BITS-1:0];
        REG_FILL_COLOR:    fill_color    <= pwdata[COLOR_BITS-1:0];
        default:           fill_color    <= fill_color;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CORNER_RADIUS: prdata = CFG_DATA_BITS'(corner_radius);
      REG_FILL_COLOR:    prdata = CFG_DATA_BITS'(fill_color);
      default:           prdata = '0;
    endcase
  end

  // The front clamps the radius and works out the rectangle edges once per
  // request, so the engine only needs running counters per corner row.
  rrsg_cmd_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .width         (width),
    .height        (height),
    .corner_radius (corner_radius),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  // The queue lets the front take a new request while the engine is still
  // working through the rows of an earlier one.
  rrsg_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The engine emits, per corner row, a top span and a mirrored bottom span,
  // then the middle rectangle flagged as last. Between rows it advances the
  // inset one step per cycle until the quarter-circle sum reaches the row's
  // square.
  rrsg_span_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .fill_color (fill_color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .span_kind  (span_kind),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .draw_color (draw_color),
    .last       (last),
    .status     (eng_status)
  );

`include "rounded_rect_span_generator_top_assert.svh"

  // Only the filled rectangle closes a request.
  `RRSG_ASSERT_NOW(a_last_is_rect, out_valid && last, span_kind == SPAN_RECT,
                   "last result is not a filled rectangle")
  // A horizontal span lies on a single row.
  `RRSG_ASSERT_NOW(a_line_flat, out_valid && (span_kind == SPAN_LINE), y_start == y_end,
                   "horizontal span spans more than one row")
  // The inset search never walks past the corner radius.
  `RRSG_ASSERT_NOW(a_inset_bound, eng_status.busy, eng_status.inset <= eng_status.radius,
                   "corner inset exceeds the radius")

endmodule
